@@ hw/rtl/ssp_pkg.sv @@
// package for the seven segment page refresher: constants, codes, segment rom
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int VISIBLE_DIGITS = 4;
    localparam int TIME_BITS      = 32;
    localparam int CMP_BITS       = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int NUM_CHARS      = 8;
    localparam int NUM_DOTS       = 4;
    localparam int CHECK_SLOT     = NUM_CHARS - VISIBLE_DIGITS - 1;
    localparam int CTL_PAIRS      = 5;

    localparam int S_TDATA_BITS   = 48;
    localparam int M_TDATA_BITS   = 16;
    localparam int CFG_BITS       = 32;

    typedef enum logic [1:0] {
        MODE_POLL  = 2'd0,
        MODE_CHAR  = 2'd1,
        MODE_DOT   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_INTENSITY = 2'd0,
        CFG_REFRESH   = 2'd1,
        CFG_PAGE_TIME = 2'd2,
        CFG_NONE      = 2'd3
    } cfg_index_t;

    // controller register addresses and values
    localparam logic [7:0] ADDR_RESET     = 8'hFF;
    localparam logic [7:0] ADDR_MODE      = 8'hFC;
    localparam logic [7:0] ADDR_DECODE    = 8'h09;
    localparam logic [7:0] ADDR_SCAN      = 8'h0B;
    localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
    localparam logic [7:0] MODE_VALUE     = 8'h0F;
    localparam logic [7:0] WIDE_INTENSITY = 8'hFF;
    localparam logic [7:0] WIDE_SCAN      = 8'h07;
    localparam logic [7:0] ALL_SEGMENTS   = 8'hFF;
    localparam logic [7:0] DOT_BIT        = 8'h80;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] MAX_INTENSITY  = 8'h0F;
    localparam logic [7:0] RESET_INTENSITY = 8'd8;
    localparam logic [31:0] RESET_REFRESH   = 32'd100000;
    localparam logic [31:0] RESET_PAGE_TIME = 32'd1000000;

    localparam logic [7:0] SEG_ROM [128] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h80,8'h40,8'h20,8'h10,8'h08,8'h04,8'h02,8'h01,
        8'h48,8'h24,8'h12,8'h30,8'h25,8'h01,8'h13,8'h06,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h80,8'h01,8'h80,8'h25,
        8'h7E,8'h30,8'h6D,8'h79,8'h33,8'h5B,8'h5F,8'h70,
        8'h7F,8'h7B,8'h00,8'h00,8'h00,8'h09,8'h00,8'h00,
        8'h00,8'h77,8'h7F,8'h4E,8'h7E,8'h4F,8'h47,8'h5E,
        8'h37,8'h30,8'h3C,8'h37,8'h0E,8'h76,8'h37,8'h7E,
        8'h67,8'h7E,8'h77,8'h5B,8'h70,8'h3E,8'h3E,8'h3E,
        8'h37,8'h33,8'h6D,8'h4E,8'h13,8'h78,8'h62,8'h08,
        8'h02,8'h7D,8'h1F,8'h0D,8'h3D,8'h6F,8'h47,8'h7B,
        8'h17,8'h0C,8'h18,8'h37,8'h0E,8'h15,8'h15,8'h1D,
        8'h67,8'h73,8'h05,8'h5B,8'h0F,8'h1C,8'h1C,8'h1C,
        8'h37,8'h3B,8'h6D,8'h4E,8'h30,8'h78,8'h01,8'h00
    };

    function automatic logic [7:0] seg_pattern(input logic [7:0] code);
        logic [7:0] pat;
        pat = code[7] ? 8'h00 : SEG_ROM[code[6:0]];
        return pat;
    endfunction

endpackage

@@ hw/rtl/seven_segment_page_refresher.sv @@
// seven segment page refresher: frame store, page timing and register pair stream
`timescale 1ns / 1ps

// channel  dir  tdata fields (low bit up)                         tuser  tlast
// s_axis   in   now_us[31:0] position[34:32] char_code[42:35]     mode   -
//               dot_on[43], zero fill to 48
// m_axis   out  reg_addr[7:0] reg_data[15:8]                      -      last
// cfg      in   cfg_we, cfg_index (0 intensity, 1 refresh, 2 page time), cfg_wdata
//
// state updates and the pair list of an item are fixed in the cycle it is taken
// a poll then streams its 0..13 pairs one per cycle through the output register while m_axis_tready allows
// the next item is taken in the cycle the final pair of a poll enters that register
// writes and clears produce no pairs and can be taken every cycle while no poll is streaming
// rst_n clears frame, dots, timestamps, page flag, loads the config defaults and sets the control run pending
module seven_segment_page_refresher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ssp_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,  // now_us, position, char_code, dot_on
    input  logic [1:0]                        s_axis_tuser,  // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ssp_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,  // reg_addr, reg_data
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [ssp_pkg::CFG_BITS-1:0]      cfg_wdata
);
    import ssp_pkg::*;

    // configuration
    logic [7:0]            intensity_reg;
    logic [31:0]           refresh_period_reg;
    logic [31:0]           page_time_reg;

    // display state
    logic [7:0]            chars_reg [NUM_CHARS];
    logic [7:0]            chars_next [NUM_CHARS];
    logic                  dots_reg [NUM_DOTS];
    logic                  dots_next [NUM_DOTS];
    logic [TIME_BITS-1:0]  last_refresh_reg;
    logic [TIME_BITS-1:0]  last_refresh_next;
    logic [TIME_BITS-1:0]  page_switch_reg;
    logic [TIME_BITS-1:0]  page_switch_next;
    logic                  page_reg;
    logic                  page_next;
    logic                  pending_reg;
    logic                  pending_next;

    // job and output
    logic                  busy_reg;
    logic                  busy_next;
    logic [3:0]            cnt_reg;
    logic [3:0]            cnt_next;
    logic [3:0]            total_reg;
    logic [3:0]            total_next;
    logic                  jctl_reg;
    logic                  jctl_next;
    logic [7:0]            dig_reg [VISIBLE_DIGITS];
    logic [7:0]            dig_next [VISIBLE_DIGITS];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [15:0]           out_data_reg;
    logic [15:0]           out_data_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    // input fields
    mode_t                 mode;
    logic [31:0]           now_us;
    logic [2:0]            position;
    logic [7:0]            char_code;
    logic                  dot_on;
    logic [TIME_BITS-1:0]  now_t;

    logic                  accept;
    logic                  push;
    logic                  last_pair;
    logic                  wide;
    logic                  refresh_due;
    logic                  page_due;
    logic                  check_nz;
    logic [TIME_BITS-1:0]  elapsed_ref;
    logic [TIME_BITS-1:0]  elapsed_page;
    logic [7:0]            pg1_seg [VISIBLE_DIGITS];
    logic [7:0]            pg2_seg [VISIBLE_DIGITS];
    logic                  dig_dot [VISIBLE_DIGITS];
    logic [2:0]            j_idx;
    logic [7:0]            pair_addr;
    logic [7:0]            pair_data;
    logic [7:0]            cfg_int;

    assign mode      = mode_t'(s_axis_tuser);
    assign now_us    = s_axis_tdata[31:0];
    assign position  = s_axis_tdata[34:32];
    assign char_code = s_axis_tdata[42:35];
    assign dot_on    = s_axis_tdata[43];
    assign now_t     = TIME_BITS'(now_us);

    assign wide         = (intensity_reg == WIDE_INTENSITY);
    assign elapsed_ref  = now_t - last_refresh_reg;
    assign elapsed_page = now_t - page_switch_reg;
    assign refresh_due  = CMP_BITS'(elapsed_ref) >= CMP_BITS'(refresh_period_reg);
    assign page_due     = CMP_BITS'(elapsed_page) > CMP_BITS'(page_time_reg);

    assign push      = busy_reg && (!out_valid_reg || m_axis_tready);
    assign last_pair = (cnt_reg == (total_reg - 4'd1));
    assign s_axis_tready = !busy_reg || (push && last_pair);
    assign accept    = s_axis_tvalid && s_axis_tready;

    generate
        if (CHECK_SLOT >= 0) begin : g_check
            assign check_nz = (chars_reg[CHECK_SLOT] != 8'h00);
        end else begin : g_nocheck
            assign check_nz = 1'b0;
        end
    endgenerate

    // segment patterns for both pages, each digit from fixed slots
    generate
        for (genvar k = 0; k < VISIBLE_DIGITS; k++) begin : g_dig
            localparam int SLOT1 = NUM_CHARS - k - 1;
            localparam int SLOT2 = NUM_CHARS - VISIBLE_DIGITS - k - 1;
            assign pg1_seg[k] = seg_pattern(chars_reg[SLOT1]);
            if (SLOT2 >= 0) begin : g_p2
                assign pg2_seg[k] = seg_pattern(chars_reg[SLOT2]);
            end else begin : g_p2z
                assign pg2_seg[k] = seg_pattern(8'h00);
            end
            if (k < NUM_DOTS) begin : g_dot
                assign dig_dot[k] = dots_reg[k];
            end else begin : g_nodot
                assign dig_dot[k] = 1'b0;
            end
        end
    endgenerate

    // item handling and job setup
    always_comb
    begin
        chars_next        = chars_reg;
        dots_next         = dots_reg;
        last_refresh_next = last_refresh_reg;
        page_switch_next  = page_switch_reg;
        page_next         = page_reg;
        pending_next      = pending_reg;
        busy_next         = busy_reg;
        cnt_next          = cnt_reg;
        total_next        = total_reg;
        jctl_next         = jctl_reg;
        dig_next          = dig_reg;

        if (push)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (last_pair)
            begin
                busy_next = 1'b0;
            end
        end

        if (accept)
        begin
            unique case (mode)
                MODE_CHAR:
                begin
                    for (int p = 0; p < NUM_CHARS; p++)
                    begin
                        if (3'(p) == position)
                        begin
                            chars_next[p] = char_code;
                        end
                        else if ((3'(p) > position) && (chars_reg[p] == 8'h00))
                        begin
                            chars_next[p] = SPACE_CHAR;
                        end
                    end
                end
                MODE_DOT:
                begin
                    for (int d = 0; d < NUM_DOTS; d++)
                    begin
                        if (3'(d) == position)
                        begin
                            dots_next[d] = dot_on;
                        end
                    end
                end
                MODE_CLEAR:
                begin
                    for (int p = 0; p < NUM_CHARS; p++)
                    begin
                        chars_next[p] = 8'h00;
                    end
                    for (int d = 0; d < NUM_DOTS; d++)
                    begin
                        dots_next[d] = 1'b0;
                    end
                end
                MODE_POLL:
                begin
                    jctl_next    = pending_reg;
                    pending_next = 1'b0;
                    total_next   = pending_reg ? 4'(CTL_PAIRS) : 4'd0;
                    if (refresh_due)
                    begin
                        last_refresh_next = now_t;
                        if (check_nz)
                        begin
                            if (page_due)
                            begin
                                page_next        = !page_reg;
                                page_switch_next = now_t;
                            end
                        end
                        else
                        begin
                            page_next = 1'b0;
                        end
                        total_next = total_next
                                   + (wide ? 4'(NUM_CHARS) : 4'(VISIBLE_DIGITS));
                    end
                    for (int k = 0; k < VISIBLE_DIGITS; k++)
                    begin
                        dig_next[k] = (page_next ? pg2_seg[k] : pg1_seg[k])
                                    | (dig_dot[k] ? DOT_BIT : 8'h00);
                    end
                    cnt_next  = 4'd0;
                    busy_next = (total_next != 4'd0);
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end

        if (cfg_we && (cfg_index_t'(cfg_index) == CFG_INTENSITY))
        begin
            pending_next = 1'b1;
        end
    end

    // pair selection for the current count
    always_comb
    begin
        j_idx     = 3'(cnt_reg - (jctl_reg ? 4'(CTL_PAIRS) : 4'd0));
        pair_addr = 8'(j_idx) + 8'd1;
        pair_data = ALL_SEGMENTS;
        for (int k = 0; k < VISIBLE_DIGITS; k++)
        begin
            if (j_idx == 3'(k))
            begin
                pair_data = dig_reg[k];
            end
        end
        if (jctl_reg && (cnt_reg < 4'(CTL_PAIRS)))
        begin
            unique case (cnt_reg[2:0])
                3'd0:
                begin
                    pair_addr = ADDR_RESET;
                    pair_data = 8'h00;
                end
                3'd1:
                begin
                    pair_addr = ADDR_MODE;
                    pair_data = MODE_VALUE;
                end
                3'd2:
                begin
                    pair_addr = ADDR_DECODE;
                    pair_data = 8'h00;
                end
                3'd3:
                begin
                    pair_addr = ADDR_SCAN;
                    pair_data = wide ? WIDE_SCAN : 8'(VISIBLE_DIGITS - 1);
                end
                default:
                begin
                    pair_addr = ADDR_INTENSITY;
                    pair_data = wide ? 8'h00 : intensity_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {pair_data, pair_addr};
            out_last_next  = last_pair;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cfg_int = (cfg_wdata[7:0] > MAX_INTENSITY && cfg_wdata[7:0] != WIDE_INTENSITY)
                   ? MAX_INTENSITY : cfg_wdata[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_reg      <= RESET_INTENSITY;
            refresh_period_reg <= RESET_REFRESH;
            page_time_reg      <= RESET_PAGE_TIME;
            for (int p = 0; p < NUM_CHARS; p++)
            begin
                chars_reg[p] <= 8'h00;
            end
            for (int d = 0; d < NUM_DOTS; d++)
            begin
                dots_reg[d] <= 1'b0;
            end
            last_refresh_reg <= '0;
            page_switch_reg  <= '0;
            page_reg         <= 1'b0;
            pending_reg      <= 1'b1;
            busy_reg         <= 1'b0;
            cnt_reg          <= 4'd0;
            total_reg        <= 4'd0;
            jctl_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            chars_reg        <= chars_next;
            dots_reg         <= dots_next;
            last_refresh_reg <= last_refresh_next;
            page_switch_reg  <= page_switch_next;
            page_reg         <= page_next;
            pending_reg      <= pending_next;
            busy_reg         <= busy_next;
            cnt_reg          <= cnt_next;
            total_reg        <= total_next;
            jctl_reg         <= jctl_next;
            out_valid_reg    <= out_valid_next;
            out_last_reg     <= out_last_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_INTENSITY:
                    begin
                        intensity_reg <= cfg_int;
                    end
                    CFG_REFRESH:
                    begin
                        refresh_period_reg <= cfg_wdata;
                    end
                    CFG_PAGE_TIME:
                    begin
                        page_time_reg <= cfg_wdata;
                    end
                    CFG_NONE:
                    begin
                        intensity_reg <= intensity_reg;
                    end
                    default:
                    begin
                        intensity_reg <= intensity_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dig_reg      <= dig_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
